// ===== sv/scld_pkg.sv =====
// Shared types and constants of the serial command line decoder.
// Holds the command text table and the control/status structs.
// No dependencies.
package scld_pkg;

  localparam int CMD_NUM  = 13;
  localparam int TEXT_MAX = 18;
  localparam int ARG_CAP  = 56;

  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;

  localparam logic [8*TEXT_MAX-1:0] CMD_TEXT [CMD_NUM] = '{
    "GET.TIME", "UPDATE.TIME", "SET.WAKE.TIME.", "GET.WAKE.TIME",
    "SET.LAMP.INTERVAL.", "GET.LAMP.INTERVAL", "GET.ALL.SSIDS", "CONNECT.",
    "DISCONNECT", "GET.IS.CONNECTED", "GET.IP.ADDRESS", "GET.SSID", "GET.STATUS"
  };
  localparam logic [4:0] CMD_LEN [CMD_NUM] = '{
    5'd8, 5'd11, 5'd14, 5'd13, 5'd18, 5'd17, 5'd13, 5'd8, 5'd10, 5'd16,
    5'd14, 5'd8, 5'd10
  };
  localparam logic [3:0] CMD_CODE [CMD_NUM] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd12, 4'd13
  };
  localparam logic [CMD_NUM-1:0] CMD_PREFIX = 13'b0000010010100;
  localparam logic [3:0] CMD_UNKNOWN = 4'd0;

  typedef enum logic [1:0] {RS_START, RS_TAIL, RS_POS} rd_sel_t;

  typedef struct packed {
    rd_sel_t rsel;
    logic    lf_load;
    logic    lead_inc;
    logic    trail_dec;
    logic    match_init;
    logic    match_step;
    logic    pick;
    logic    arg_step;
    logic    emit_arg;
    logic    emit_one;
    logic    unknown;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic blank;
    logic dollar;
    logic match_done;
    logic arg_go;
    logic arg_last;
    logic out_free;
  } sts_t;

  // Character j of command idx; zero past its end.
  function automatic logic [7:0] cmd_char(input int unsigned idx, input logic [4:0] j);
    logic [8*TEXT_MAX-1:0] t;
    int unsigned l;
    t = CMD_TEXT[idx];
    l = CMD_LEN[idx];
    if (j >= l) return 8'h00;
    return t[8*(l-1-j) +: 8];
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'd32 || b == 8'd9 || b == 8'd11 || b == 8'd12;
  endfunction

endpackage

// ===== sv/scld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/scld_ctrl.sv =====
// Controller state machine of the line decoder.
// Depends on scld_pkg (ctl_t, sts_t).
module scld_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           in_lf,
  input  scld_pkg::sts_t sts,
  output logic           idle,
  output scld_pkg::ctl_t ctl
);
  typedef enum logic [3:0] {
    S_IDLE, S_LEAD_RD, S_LEAD_EV, S_TRAIL_RD, S_TRAIL_EV, S_DOL_RD, S_DOL_EV,
    S_MATCH_RD, S_MATCH_EV, S_PICK, S_ARG_RD, S_ARG_EV, S_ONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.rsel = scld_pkg::RS_START;
    idle = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire && in_lf) begin
          ctl.lf_load = 1'b1;
          state_nxt = S_LEAD_RD;
        end
      end
      S_LEAD_RD: begin
        if (sts.empty) state_nxt = S_IDLE;
        else           state_nxt = S_LEAD_EV;
      end
      S_LEAD_EV: begin
        if (sts.blank) begin
          ctl.lead_inc = 1'b1;
          state_nxt = S_LEAD_RD;
        end else state_nxt = S_TRAIL_RD;
      end
      S_TRAIL_RD: begin
        ctl.rsel = scld_pkg::RS_TAIL;
        state_nxt = S_TRAIL_EV;
      end
      S_TRAIL_EV: begin
        ctl.rsel = scld_pkg::RS_TAIL;
        if (sts.blank) begin
          ctl.trail_dec = 1'b1;
          state_nxt = S_TRAIL_RD;
        end else state_nxt = S_DOL_RD;
      end
      S_DOL_RD: state_nxt = S_DOL_EV;
      S_DOL_EV: begin
        if (sts.dollar) begin
          ctl.match_init = 1'b1;
          state_nxt = S_MATCH_RD;
        end else begin
          ctl.unknown = 1'b1;
          state_nxt = S_ONE;
        end
      end
      S_MATCH_RD: begin
        ctl.rsel = scld_pkg::RS_POS;
        if (sts.match_done) state_nxt = S_PICK;
        else                state_nxt = S_MATCH_EV;
      end
      S_MATCH_EV: begin
        ctl.rsel = scld_pkg::RS_POS;
        ctl.match_step = 1'b1;
        state_nxt = S_MATCH_RD;
      end
      S_PICK: begin
        ctl.pick = 1'b1;
        if (sts.arg_go) state_nxt = S_ARG_RD;
        else            state_nxt = S_ONE;
      end
      S_ARG_RD: begin
        ctl.rsel = scld_pkg::RS_POS;
        state_nxt = S_ARG_EV;
      end
      S_ARG_EV: begin
        ctl.rsel = scld_pkg::RS_POS;
        if (sts.out_free) begin
          ctl.emit_arg = 1'b1;
          ctl.arg_step = 1'b1;
          state_nxt = sts.arg_last ? S_IDLE : S_ARG_RD;
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          ctl.emit_one = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== sv/scld_dp.sv =====
// Datapath of the line decoder: line store, trim pointers, command match
// flags, argument counter and output register. Depends on scld_pkg, scld_ram.
module scld_dp #(
  parameter int LINE_MAX = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [7:0]     in_byte,
  input  scld_pkg::ctl_t ctl,
  output scld_pkg::sts_t sts,
  input  logic           out_tready,
  output logic           out_tvalid,
  output logic [3:0]     out_command,
  output logic [7:0]     out_arg_byte,
  output logic           out_arg_valid,
  output logic           out_last
);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int AW = $clog2(LINE_MAX);
  localparam int NC = scld_pkg::CMD_NUM;

  logic [LW-1:0] len_r, start_r, end_r, pos_r;
  logic [4:0]    j_r;
  logic [NC-1:0] alive_r;
  logic [3:0]    cmd_r;
  logic [5:0]    cnt_r;
  logic          ov_r;
  logic [3:0]    oc_r;
  logic [7:0]    ob_r;
  logic          oa_r, ol_r;

  logic          we;
  logic [LW-1:0] raddr_w, tail, blen, argpos, nrem;
  logic [7:0]    rdata;
  logic [NC-1:0] hit;
  logic          any_hit;
  int unsigned   sel;

  assign we = in_fire && in_byte != scld_pkg::CHAR_CR && in_byte != scld_pkg::CHAR_LF
              && len_r < LW'(LINE_MAX);
  assign tail = end_r - LW'(1);

  always_comb begin
    case (ctl.rsel)
      scld_pkg::RS_TAIL: raddr_w = tail;
      scld_pkg::RS_POS:  raddr_w = pos_r;
      default:           raddr_w = start_r;
    endcase
  end

  scld_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(len_r[AW-1:0]),
    .wdata(in_byte),
    .raddr(raddr_w[AW-1:0]),
    .rdata(rdata)
  );

  // Resolve the match: first surviving command whose length fits the body.
  assign blen = end_r - start_r - LW'(1);
  always_comb begin
    any_hit = 1'b0;
    sel = 0;
    for (int i = 0; i < NC; i++) begin
      hit[i] = alive_r[i] && (scld_pkg::CMD_PREFIX[i] ? blen >= LW'(scld_pkg::CMD_LEN[i])
                                                      : blen == LW'(scld_pkg::CMD_LEN[i]));
    end
    for (int i = NC - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        sel = i;
      end
    end
  end
  assign argpos = start_r + LW'(1) + LW'(scld_pkg::CMD_LEN[sel]);
  assign nrem   = end_r - argpos;

  assign sts.empty      = start_r == end_r;
  assign sts.blank      = scld_pkg::is_blank(rdata);
  assign sts.dollar     = rdata == scld_pkg::CHAR_DOLLAR;
  assign sts.match_done = j_r == 5'(scld_pkg::TEXT_MAX) || pos_r == end_r;
  assign sts.arg_go     = any_hit && scld_pkg::CMD_PREFIX[sel] && nrem != '0;
  assign sts.arg_last   = cnt_r == 6'd1;
  assign sts.out_free   = !ov_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (ctl.lf_load) len_r <= '0;
      else if (we)     len_r <= len_r + LW'(1);
      if (ctl.emit_arg || ctl.emit_one) ov_r <= 1'b1;
      else if (out_tready)              ov_r <= 1'b0;
    end
    if (ctl.lf_load) begin
      start_r <= '0;
      end_r   <= len_r;
    end
    if (ctl.lead_inc)  start_r <= start_r + LW'(1);
    if (ctl.trail_dec) end_r   <= tail;
    if (ctl.unknown)   cmd_r   <= scld_pkg::CMD_UNKNOWN;
    if (ctl.match_init) begin
      pos_r   <= start_r + LW'(1);
      j_r     <= '0;
      alive_r <= '1;
    end
    if (ctl.match_step) begin
      for (int i = 0; i < NC; i++) begin
        if (j_r < scld_pkg::CMD_LEN[i] && rdata != scld_pkg::cmd_char(i, j_r))
          alive_r[i] <= 1'b0;
      end
      j_r   <= j_r + 5'd1;
      pos_r <= pos_r + LW'(1);
    end
    if (ctl.pick) begin
      cmd_r <= any_hit ? scld_pkg::CMD_CODE[sel] : scld_pkg::CMD_UNKNOWN;
      pos_r <= argpos;
      cnt_r <= nrem > LW'(scld_pkg::ARG_CAP) ? 6'(scld_pkg::ARG_CAP) : nrem[5:0];
    end
    if (ctl.arg_step) begin
      pos_r <= pos_r + LW'(1);
      cnt_r <= cnt_r - 6'd1;
    end
    if (ctl.emit_arg) begin
      oc_r <= cmd_r;
      ob_r <= rdata;
      oa_r <= 1'b1;
      ol_r <= cnt_r == 6'd1;
    end
    if (ctl.emit_one) begin
      oc_r <= cmd_r;
      ob_r <= 8'h00;
      oa_r <= 1'b0;
      ol_r <= 1'b1;
    end
  end

  assign out_tvalid    = ov_r;
  assign out_command   = oc_r;
  assign out_arg_byte  = ob_r;
  assign out_arg_valid = oa_r;
  assign out_last      = ol_r;
endmodule

// ===== sv/serial_command_line_decoder_core.sv =====
// Top level of the serial command line decoder.
// Depends on scld_pkg, scld_ctrl, scld_dp (and scld_ram through scld_dp).
//
// Usage:
//  - Input channel in_*: one received byte per beat. CR is dropped, LF ends
//    the line, every other byte is stored until LINE_MAX bytes are held;
//    further bytes are dropped until the next LF.
//  - Output channel out_*: one beat per result. A line gives nothing (empty
//    after trimming blanks), one command beat, or one beat per argument
//    byte of a prefix command (capped at 56); tlast marks the line's end.
//  - Input hold: ordinary bytes are taken without a pause. After an LF the
//    input is held while the decoder trims blanks at each end, checks for a
//    leading dollar, compares body bytes (at most 18) and emits the command
//    beat or the argument beats, one read of the line store at a time.
//  - Results go through one output register: a new result is loaded when
//    it is empty or being taken, so a stalled receiver holds the decoder
//    in its emit step; ordinary bytes are still taken while the last beat
//    of a line waits.
//  - Reset (rst_n low, synchronous) empties the line and output register.
module serial_command_line_decoder_core #(
  parameter int LINE_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] command, [11:4] arg_byte, [12] arg_valid
  output logic        out_tlast   // last
);
  scld_pkg::ctl_t ctl;
  scld_pkg::sts_t sts;
  logic           idle, in_fire;
  logic [3:0]     cmd;
  logic [7:0]     arg;
  logic           argv;

  // Accept bytes only while the controller is not working on a line.
  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  scld_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_lf  (in_tdata == scld_pkg::CHAR_LF),
    .sts    (sts),
    .idle   (idle),
    .ctl    (ctl)
  );

  scld_dp #(.LINE_MAX(LINE_MAX)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_byte      (in_tdata),
    .ctl          (ctl),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_command  (cmd),
    .out_arg_byte (arg),
    .out_arg_valid(argv),
    .out_last     (out_tlast)
  );

  // Pack the result beat, padded to whole bytes.
  assign out_tdata = {3'b000, argv, arg, cmd};
endmodule

// ===== bench/testbench.sv =====
// Testbench for serial_command_line_decoder_core: streams bytes into the decoder
// and checks every output beat against an in-bench line predictor.
// Depends on scld_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int LINE_CAP   = 64;
  localparam int STALL_MAX  = 5;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] arg_byte;
    logic       arg_valid;
    logic       last;
  } dec_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  serial_command_line_decoder_core #(.LINE_MAX(LINE_CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Predictor state: the line collected so far.
  logic [7:0]  pend_line [LINE_CAP];
  int          pend_len;
  dec_result_t expected_beats [$];

  int  fail_count = 0;
  int  beats_seen = 0;
  int  lines_sent;
  int  bytes_sent;
  int  idle_cycles = 0;

  // Command table, in match order.
  string       cmd_names [scld_pkg::CMD_NUM];
  logic [3:0]  cmd_codes [scld_pkg::CMD_NUM];
  bit          cmd_is_prefix [scld_pkg::CMD_NUM];

  initial begin
    cmd_names = '{"GET.TIME", "UPDATE.TIME", "SET.WAKE.TIME.", "GET.WAKE.TIME",
                  "SET.LAMP.INTERVAL.", "GET.LAMP.INTERVAL", "GET.ALL.SSIDS",
                  "CONNECT.", "DISCONNECT", "GET.IS.CONNECTED", "GET.IP.ADDRESS",
                  "GET.SSID", "GET.STATUS"};
    for (int i = 0; i < scld_pkg::CMD_NUM; i++) begin
      cmd_codes[i] = 4'(i + 1);
      cmd_is_prefix[i] = (i == 2 || i == 4 || i == 7);
    end
  end

  function automatic bit blank_char(logic [7:0] b);
    return b == 8'd32 || b == 8'd9 || b == 8'd11 || b == 8'd12;
  endfunction

  // Decode the collected line at a line feed and queue its results.
  function automatic void decode_line();
    int lo, hi, body, blen, argpos, n, clen;
    logic [3:0] code;
    bit has_arg, hit;
    dec_result_t r;
    lo = 0;
    hi = pend_len;
    pend_len = 0;
    code = scld_pkg::CMD_UNKNOWN;
    has_arg = 0;
    while (lo < hi && blank_char(pend_line[lo])) lo++;
    while (hi > lo && blank_char(pend_line[hi-1])) hi--;
    if (lo == hi) return;
    argpos = hi;
    if (pend_line[lo] == scld_pkg::CHAR_DOLLAR) begin
      body = lo + 1;
      blen = hi - body;
      for (int i = 0; i < scld_pkg::CMD_NUM; i++) begin
        clen = cmd_names[i].len();
        hit = cmd_is_prefix[i] ? (blen >= clen) : (blen == clen);
        for (int j = 0; j < clen && hit; j++)
          if (pend_line[body+j] != cmd_names[i][j]) hit = 0;
        if (hit) begin
          code = cmd_codes[i];
          has_arg = cmd_is_prefix[i];
          argpos = body + clen;
          break;
        end
      end
    end
    if (!has_arg || argpos >= hi) begin
      r = '{command: code, arg_byte: 8'd0, arg_valid: 1'b0, last: 1'b1};
      expected_beats.push_back(r);
      return;
    end
    n = hi - argpos;
    if (n > scld_pkg::ARG_CAP) n = scld_pkg::ARG_CAP;
    for (int k = 0; k < n; k++) begin
      r = '{command: code, arg_byte: pend_line[argpos+k], arg_valid: 1'b1,
            last: (k + 1 == n)};
      expected_beats.push_back(r);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    if (b == scld_pkg::CHAR_CR) return;
    if (b != scld_pkg::CHAR_LF) begin
      if (pend_len < LINE_CAP) begin
        pend_line[pend_len] = b;
        pend_len++;
      end
      return;
    end
    lines_sent++;
    decode_line();
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one byte after a random gap; hold until the decoder takes it.
  // Valid stays high after the beat until the next gap or drain pause.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, STALL_MAX);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(string s);
    send_text(s);
    send_byte(scld_pkg::CHAR_LF);
  endtask

  function automatic logic [7:0] rand_arg_char();
    return 8'($urandom_range(33, 126));
  endfunction

  // Drain pause: drop valid and wait until every queued result has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver: draw a random wait before each beat.
  initial begin
    int wait_cyc;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      wait_cyc = $urandom_range(0, STALL_MAX);
      if (wait_cyc != 0) begin
        out_tready <= 1'b0;
        repeat (wait_cyc) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    dec_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{command: out_tdata[3:0], arg_byte: out_tdata[11:4],
              arg_valid: out_tdata[12], last: out_tlast};
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: command %0d arg_byte %0h", got.command, got.arg_byte);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (got.command !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, got.command);
          fail_count++;
        end
        if (got.arg_byte !== want.arg_byte) begin
          $error("arg_byte: expected %0h, got %0h", want.arg_byte, got.arg_byte);
          fail_count++;
        end
        if (got.arg_valid !== want.arg_valid) begin
          $error("arg_valid: expected %0b, got %0b", want.arg_valid, got.arg_valid);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Every exact command, every prefix command with an argument, one without.
  task automatic test_all_commands();
    for (int i = 0; i < scld_pkg::CMD_NUM; i++) begin
      if (cmd_is_prefix[i]) begin
        send_line({"$", cmd_names[i], "ab"});
        if (cmd_names[i] == "CONNECT.") send_line({"$", cmd_names[i]});
      end else begin
        send_line({"$", cmd_names[i]});
      end
    end
  endtask

  // Empty, blank-only, CR handling, trimming, no dollar, near misses.
  task automatic test_special_lines();
    send_byte(scld_pkg::CHAR_LF);
    send_line(" \t\v\f ");
    send_text("\t $GET.TIME");
    send_byte(scld_pkg::CHAR_CR);
    send_line(" \f");
    send_line("GET.TIME");
    send_line("$GET.TIM");
    send_line("$GET.TIMEX");
    send_line("$");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_line("$CONNECT. x y ");
  endtask

  // Overlong line saturates; the kept argument fills the line.
  task automatic test_saturation();
    send_text("$CONNECT.");
    for (int i = 0; i < 56; i++) send_byte(rand_arg_char());
    send_byte(scld_pkg::CHAR_LF);
    wait_drained();
  endtask

  // Random lines: mostly well-formed commands with random arguments and blanks.
  task automatic test_random_lines(int target_bytes);
    int stop_at, pick, nargs;
    logic [7:0] b;
    stop_at = bytes_sent + target_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      repeat ($urandom_range(0, 1)) send_byte(blank_char(8'd32) ? 8'd32 : 8'd9);
      if (pick < 7) begin
        int c;
        c = $urandom_range(0, scld_pkg::CMD_NUM - 1);
        send_text({"$", cmd_names[c]});
        if (cmd_is_prefix[c]) begin
          nargs = $urandom_range(0, 6);
          for (int k = 0; k < nargs; k++) send_byte(rand_arg_char());
        end else if ($urandom_range(0, 5) == 0) begin
          send_byte(rand_arg_char());
        end
      end else begin
        nargs = $urandom_range(0, 8);
        for (int k = 0; k < nargs; k++) begin
          b = 8'($urandom_range(0, 255));
          if (b == scld_pkg::CHAR_LF) b = 8'h24;
          send_byte(b);
        end
      end
      if ($urandom_range(0, 2) == 0) send_byte(scld_pkg::CHAR_CR);
      if ($urandom_range(0, 3) == 0) send_byte(8'd12);
      send_byte(scld_pkg::CHAR_LF);
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    pend_len = 0;
    lines_sent = 0;
    bytes_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_all_commands();
    test_special_lines();
    wait_drained();
    test_saturation();
    test_random_lines(24);

    wait_drained();
    repeat (200) @(negedge clk);

    $display("Sent %0d bytes in %0d lines; checked %0d result beats.",
             bytes_sent, lines_sent, beats_seen);
    $display("Covered all commands, trimming, CR, junk lines, a full line, random stalls.");
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (expected_beats.size() != 0)
        $error("%0d expected beats never arrived", expected_beats.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
